>>> sv/lkvc_pkg.sv
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// No dependencies; imported by the top level, lkvc_ctrl, lkvc_dpath and the testbench.
package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // command field codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_READ,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

>>> sv/lkvc_ifs.sv
// lkvc_ifs: valid/ready channel interfaces of the LRU key-value cache.
// Depends on nothing; used by the top level and its ports.
interface lkvc_cmd_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;
    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface lkvc_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: top level of the fully associative LRU cache.
// Depends on lkvc_pkg, lkvc_ifs, lkvc_ctrl, lkvc_dpath and lkvc_ram.
//
// Usage
//   i_cmd : command beats {command, key, value}; command CMD_GET looks a key
//           up, CMD_SET inserts or updates it.
//   o_rsp : one result beat per command {hit, read_value, evicted,
//           evicted_key}; fields that do not apply read as zero.
//   i_cfg : capacity write (5 bits). Zero disables the cache, values above
//           ENTRIES saturate. Every write empties the store. Always ready
//           outside reset; write only while no command is in flight.
// Timing
//   A command passes through accept, parallel tag compare against all
//   entries, value RAM read and commit (recency update of all entries, RAM
//   write, result register load). The result is visible the cycle after
//   commit. One command at a time: there are four sequencer states (the
//   registered RAM read needs its own), and no new command is accepted
//   before commit. The next command is accepted while a result still waits
//   in the output register; if the receiver stalls, the following command
//   holds in commit until the register frees up.
// Reset
//   Synchronous, active low: all entries invalid, capacity 16, no result
//   pending. No clearing pass is needed.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkvc_cmd_if.sink   i_cmd,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);
    import lkvc_pkg::*;

    t_ctrl_cmd         ctrl_cmd;
    t_dp_stat          dp_stat;
    logic              in_ready;
    logic              out_valid;
    logic              out_hit;
    logic [DATA_W-1:0] out_value;
    logic              out_evicted;
    logic [DATA_W-1:0] out_ev_key;

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    lkvc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_cmd.command),
        .i_key         (i_cmd.key),
        .i_value       (i_cmd.value),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (out_valid),
        .i_out_ready   (o_rsp.ready),
        .o_hit         (out_hit),
        .o_read_value  (out_value),
        .o_evicted     (out_evicted),
        .o_evicted_key (out_ev_key)
    );

    assign i_cmd.ready       = in_ready;
    assign i_cfg.ready       = i_rst_n;
    assign o_rsp.valid       = out_valid;
    assign o_rsp.hit         = out_hit;
    assign o_rsp.read_value  = out_value;
    assign o_rsp.evicted     = out_evicted;
    assign o_rsp.evicted_key = out_ev_key;
endmodule

>>> sv/lkvc_ram.sv
// lkvc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/lkvc_ctrl.sv
// lkvc_ctrl: command sequencer of the LRU key-value cache.
// Depends on lkvc_pkg; drives the datapath through t_ctrl_cmd.
module lkvc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lkvc_pkg::t_dp_stat i_stat,
    output lkvc_pkg::t_ctrl_cmd o_cmd
);
    import lkvc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_READ;
            end
            ST_READ: begin
                // value memory read in flight
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

>>> sv/lkvc_dpath.sv
// lkvc_dpath: tag/recency flops, value RAM and result register of the cache.
// Depends on lkvc_pkg and lkvc_ram.
module lkvc_dpath #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkvc_pkg::t_ctrl_cmd           i_cmd,
    output lkvc_pkg::t_dp_stat            o_stat,
    input  logic                          i_command,
    input  logic [lkvc_pkg::DATA_W-1:0]   i_key,
    input  logic [lkvc_pkg::DATA_W-1:0]   i_value,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [lkvc_pkg::DATA_W-1:0]   o_read_value,
    output logic                          o_evicted,
    output logic [lkvc_pkg::DATA_W-1:0]   o_evicted_key
);
    import lkvc_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (UW > CFG_W) ? UW : CFG_W;

    // captured command
    logic              r_command;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_value;

    // entry state
    logic              r_valid [ENTRIES];
    logic [DATA_W-1:0] r_keys  [ENTRIES];
    logic [IW-1:0]     r_rank  [ENTRIES];
    logic [UW-1:0]     r_used;
    logic [CFG_W-1:0]  r_cap;

    // lookup results
    logic              r_hit;
    logic              r_evict;
    logic              r_insert;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_prom_rank;
    logic [DATA_W-1:0] r_ev_key;

    // result register
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_evicted;
    logic [DATA_W-1:0] r_out_ev_key;

    logic              any_match;
    logic [IW-1:0]     match_idx;
    logic [IW-1:0]     match_rank;
    logic [IW-1:0]     old_idx;
    logic [DATA_W-1:0] old_key;
    logic [IW-1:0]     free_idx;
    logic [IW-1:0]     oldest_rank;
    logic [CMPW-1:0]   cap_eff;
    logic              full;
    logic              cap_zero;
    logic              is_set;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;

    assign is_set      = (r_command == CMD_SET);
    assign cap_zero    = (r_cap == '0);
    assign cap_eff     = (CMPW'(r_cap) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(r_cap);
    assign full        = (CMPW'(r_used) >= cap_eff);
    assign oldest_rank = IW'(r_used - UW'(1));

    // parallel tag compare; keys of valid entries are unique
    always_comb begin
        any_match  = 1'b0;
        match_idx  = '0;
        match_rank = '0;
        old_idx    = '0;
        old_key    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && (r_keys[i] == r_key)) begin
                any_match  = 1'b1;
                match_idx  = match_idx | IW'(i);
                match_rank = match_rank | r_rank[i];
            end
            // ranks of valid entries are a permutation of 0..used-1
            if (r_valid[i] && (r_rank[i] == oldest_rank)) begin
                old_idx = old_idx | IW'(i);
                old_key = old_key | r_keys[i];
            end
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_key     <= i_key;
            r_value   <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_hit       <= !cap_zero && any_match;
            r_evict     <= !cap_zero && !any_match && is_set && full;
            r_insert    <= !cap_zero && !any_match && is_set;
            r_idx       <= any_match ? match_idx : (full ? old_idx : free_idx);
            r_prom_rank <= match_rank;
            r_ev_key    <= old_key;
        end
    end

    // valid bits, fill count, capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_used <= '0;
            r_cap  <= CAP_RESET;
        end else if (i_cfg_we) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_used <= '0;
            r_cap  <= i_cfg_data;
        end else if (i_cmd.commit && r_insert) begin
            r_valid[r_idx] <= 1'b1;
            if (!r_evict) begin
                r_used <= r_used + UW'(1);
            end
        end
    end

    // keys and recency ranks
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] < r_prom_rank)) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
                r_rank[r_idx] <= '0;
            end else if (r_insert) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
                r_rank[r_idx] <= '0;
                r_keys[r_idx] <= r_key;
            end
        end
    end

    assign ram_we = i_cmd.commit && ((r_hit && is_set) || r_insert);

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_value),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit     <= r_hit;
            r_out_value   <= (r_hit && !is_set) ? ram_rdata : '0;
            r_out_evicted <= r_evict;
            r_out_ev_key  <= r_evict ? r_ev_key : '0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_read_value    = r_out_value;
    assign o_evicted       = r_out_evicted;
    assign o_evicted_key   = r_out_ev_key;
endmodule

>>> sv/lkvc_checker.sv
// lkvc_checker: port-level assertions for lru_key_value_cache_unit.
// Depends on nothing; bound to the top level at the end of this file.
module lkvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic [31:0] rsp_read_value,
    input logic        rsp_evicted,
    input logic [31:0] rsp_evicted_key
);
    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
            && $stable(rsp_evicted_key) && $stable(rsp_hit) && $stable(rsp_evicted))
        else $error("result beat changed while stalled");

    // one command in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while previous still in progress");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid)
        else $error("result valid right after reset");

    // hit and eviction are exclusive; unused fields are zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !(rsp_hit && rsp_evicted) && (rsp_hit || rsp_read_value == '0)
            && (rsp_evicted || rsp_evicted_key == '0))
        else $error("inconsistent result fields");
endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .cmd_valid       (i_cmd.valid),
    .cmd_ready       (i_cmd.ready),
    .rsp_valid       (o_rsp.valid),
    .rsp_ready       (o_rsp.ready),
    .rsp_hit         (o_rsp.hit),
    .rsp_read_value  (o_rsp.read_value),
    .rsp_evicted     (o_rsp.evicted),
    .rsp_evicted_key (o_rsp.evicted_key)
);

>>> tb/tb_lru_key_value_cache_unit.sv
// Self-checking testbench for lru_key_value_cache_unit: predicts every result beat
// with an in-bench LRU cache and compares it against the block.
// Depends on lkvc_pkg, lkvc_ifs and the RTL of lru_key_value_cache_unit.
module tb_lru_key_value_cache_unit;

    import lkvc_pkg::*;

    localparam int CACHE_SLOTS = 16;
    localparam int MAX_REPORTS = 10;

    // one result beat, as the cache should produce it
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } t_cache_rsp;

    // Mirror of the cache contents plus the queue of result beats still owed.
    class lru_scoreboard;
        logic              slot_valid [CACHE_SLOTS];
        logic [DATA_W-1:0] slot_key   [CACHE_SLOTS];
        logic [DATA_W-1:0] slot_value [CACHE_SLOTS];
        logic [3:0]        slot_rank  [CACHE_SLOTS];  // 0 = most recent
        logic [CFG_W-1:0]  slots_used;
        logic [CFG_W-1:0]  capacity;
        t_cache_rsp        owed_q[$];
        int                errors;

        function new();
            errors = 0;
            set_capacity(CAP_RESET);
        endfunction

        // a capacity write always empties the store
        function void set_capacity(logic [CFG_W-1:0] cap);
            capacity = cap;
            slots_used = '0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_rank[i]  = '0;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // works out the result beat of one accepted command and updates the mirror
        function void note_command(logic cmd, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
            t_cache_rsp rsp;
            int         match;
            int         slot;
            int         cap;
            logic [3:0] oldest;
            logic [3:0] old_rank;
            rsp    = '0;
            match  = -1;
            slot   = -1;
            oldest = '0;
            cap    = (int'(capacity) > CACHE_SLOTS) ? CACHE_SLOTS : int'(capacity);
            if (cap != 0) begin
                for (int i = 0; i < CACHE_SLOTS; i++)
                    if (match < 0 && slot_valid[i] && slot_key[i] == k)
                        match = i;
                if (match >= 0) begin
                    rsp.hit = 1'b1;
                    if (cmd == CMD_GET)
                        rsp.read_value = slot_value[match];
                    else
                        slot_value[match] = v;
                    // promote: everything younger than the hit entry ages by one
                    old_rank = slot_rank[match];
                    for (int i = 0; i < CACHE_SLOTS; i++)
                        if (slot_valid[i] && slot_rank[i] < old_rank)
                            slot_rank[i]++;
                    slot_rank[match] = '0;
                end else if (cmd == CMD_SET) begin
                    if (int'(slots_used) >= cap) begin
                        for (int i = 0; i < CACHE_SLOTS; i++)
                            if (slot_valid[i] && (slot < 0 || slot_rank[i] > oldest)) begin
                                slot   = i;
                                oldest = slot_rank[i];
                            end
                        if (slot >= 0) begin
                            rsp.evicted     = 1'b1;
                            rsp.evicted_key = slot_key[slot];
                            slot_valid[slot] = 1'b0;
                            slots_used--;
                        end
                    end
                    if (slot < 0)
                        for (int i = 0; i < CACHE_SLOTS; i++)
                            if (slot < 0 && !slot_valid[i])
                                slot = i;
                    if (slot >= 0) begin
                        for (int i = 0; i < CACHE_SLOTS; i++)
                            if (slot_valid[i])
                                slot_rank[i]++;
                        slot_valid[slot] = 1'b1;
                        slot_key[slot]   = k;
                        slot_value[slot] = v;
                        slot_rank[slot]  = '0;
                        slots_used++;
                    end
                end
            end
            owed_q.push_back(rsp);
        endfunction

        // compares one accepted result beat with the oldest owed one
        function void check_result(t_cache_rsp got);
            t_cache_rsp exp;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: hit=%0d rd=%h ev=%0d ek=%h",
                             got.hit, got.read_value, got.evicted, got.evicted_key);
                return;
            end
            exp = owed_q.pop_front();
            if (got.hit !== exp.hit || got.read_value !== exp.read_value ||
                got.evicted !== exp.evicted || got.evicted_key !== exp.evicted_key) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result mismatch: exp hit=%0d rd=%h ev=%0d ek=%h, got hit=%0d rd=%h ev=%0d ek=%h",
                             exp.hit, exp.read_value, exp.evicted, exp.evicted_key,
                             got.hit, got.read_value, got.evicted, got.evicted_key);
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lkvc_cmd_if cmd_if();
    lkvc_rsp_if rsp_if();
    lkvc_cfg_if cfg_if();

    lru_key_value_cache_unit #(
        .ENTRIES (CACHE_SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    lru_scoreboard     sb = new();
    logic [DATA_W-1:0] key_pool[32];
    bit                sender_quiet = 1'b0;  // back-to-back command beats when set
    int                rsp_hold_cycles = 0;  // long receiver hold-off, taken by the sink process

    always #5 i_clk = ~i_clk;

    // Hard limit: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // no gap when quiet; otherwise half the beats go without one, the rest wait a random gap
    function automatic int draw_gap(bit quiet);
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return int'($urandom_range(0, 15));
    endfunction

    // mostly keys from a small pool so gets hit and sets evict; some fully random
    function automatic logic [DATA_W-1:0] pick_key(int span);
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, span - 1)];
        return $urandom;
    endfunction

    // Offers one command beat and returns at the edge it is taken. valid is left high
    // so a following beat with no gap goes out without a bubble.
    task automatic send_cmd(input logic c, input logic [DATA_W-1:0] k,
                            input logic [DATA_W-1:0] v);
        int gap;
        gap = draw_gap(sender_quiet);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= c;
        cmd_if.key     <= k;
        cmd_if.value   <= v;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(c, k, v);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // capacity writes only while nothing is in flight
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= cap;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.set_capacity(cap);
        cfg_if.valid <= 1'b0;
    endtask

    // Random gets and sets. With pause_mid the sender stops halfway until every
    // owed result beat is back.
    task automatic run_phase(input int n, input int span, input bit pause_mid);
        logic c;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0)
                sender_quiet = ($urandom_range(0, 2) == 0);
            if (pause_mid && i == n / 2) begin
                cmd_if.valid <= 1'b0;
                wait_drained();
            end
            c = $urandom_range(0, 1) ? CMD_SET : CMD_GET;
            send_cmd(c, pick_key(span), $urandom);
        end
        cmd_if.valid <= 1'b0;
    endtask

    // Result sink: random ready gaps, quiet stretches, and the long hold-off on request.
    initial begin
        t_cache_rsp got;
        int         wait_n;
        int         beats;
        bit         quiet;
        beats = 0;
        quiet = 1'b0;
        rsp_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (rsp_hold_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge i_clk);
                rsp_hold_cycles = 0;
            end
            wait_n = draw_gap(quiet);
            if (wait_n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            got.hit         = rsp_if.hit;
            got.read_value  = rsp_if.read_value;
            got.evicted     = rsp_if.evicted;
            got.evicted_key = rsp_if.evicted_key;
            sb.check_result(got);
            beats++;
        end
    end

    // Main sequence: reset, directed beats at the reset capacity, then random phases
    // over a spread of capacities, including zero and values that saturate.
    initial begin
        logic [CFG_W-1:0] phase_cap[10];
        int               eff;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_GET;
        cmd_if.key     <= '0;
        cmd_if.value   <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 32; i++)
            key_pool[i] = $urandom;

        phase_cap = '{5'd1, 5'd2, 5'd0, 5'd16, 5'd31, 5'd5, 5'd17, 5'd3, 5'd8, 5'd16};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: miss on the empty store, key/value extremes, update of a present
        // key, fill to capacity, then a set that evicts the least recent entry
        send_cmd(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(CMD_SET, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_cmd(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_cmd(CMD_SET, 32'h0000_0000, 32'h1234_5678);  // hit on set, no read data
        send_cmd(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        for (int i = 1; i <= 12; i++)
            send_cmd(CMD_SET, i * 32'h0101_0101, ~(i * 32'h0101_0101));
        send_cmd(CMD_SET, 32'h0BAD_F00D, 32'h5555_AAAA);  // evicts key all-ones
        send_cmd(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);  // evicted key now misses
        cmd_if.valid <= 1'b0;

        foreach (phase_cap[p]) begin
            write_capacity(phase_cap[p]);
            eff = (int'(phase_cap[p]) > CACHE_SLOTS) ? CACHE_SLOTS : int'(phase_cap[p]);
            // first full-size phase: long sink stall so the block backs up and
            // stalls its command input
            if (p == 3)
                rsp_hold_cycles = 300;
            run_phase((eff == 0) ? 60 : 160, (eff + 6 > 32) ? 32 : eff + 6, p == 5);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);  // catch any stray beat after the last one
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
